@@ rtl/prefix_code_bit_packer_top_assert.svh @@
// ----------------------------------------------------------------------------
// prefix code bit packer assertion macros
// Shared property forms for the checker of the bit packer.
// ----------------------------------------------------------------------------
`ifndef PREFIX_CODE_BIT_PACKER_TOP_ASSERT_SVH
`define PREFIX_CODE_BIT_PACKER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PCBP_AST_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcbp same-cycle property failed");

// next-cycle implication, sampled on clk, off during reset
`define PCBP_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcbp next-cycle property failed");

`endif

@@ rtl/pcbp_pkg.sv @@
// ----------------------------------------------------------------------------
// pcbp_pkg
// Action codes and default sizes of the prefix code bit packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

	localparam logic [1:0] ACT_LOAD   = 2'd0;
	localparam logic [1:0] ACT_ENCODE = 2'd1;
	localparam logic [1:0] ACT_FINISH = 2'd2;

	localparam int MAX_CODE_LEN_DEF = 64;
	localparam int NUM_SYMBOLS_DEF  = 129;

	// entries in the command queue between front and back
	localparam int QUEUE_DEPTH = 2;

	localparam int BYTE_W = 8;
	// pending bits never reach a full byte
	localparam int PEND_W = 7;
	localparam int PCNT_W = 3;

endpackage

@@ rtl/pcbp_ram.sv @@
// ----------------------------------------------------------------------------
// pcbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/pcbp_fifo.sv @@
// ----------------------------------------------------------------------------
// pcbp_fifo
// Short command queue between the lookup front and the packing back.
// ----------------------------------------------------------------------------
module pcbp_fifo
	import pcbp_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             room,
	input  logic             pop,
	output logic             avail,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CNT_W-1:0] fill_q;
	logic             do_push;
	logic             do_pop;

	assign room     = (fill_q != CNT_W'(DEPTH));
	assign avail    = (fill_q != '0);
	assign do_push  = push && room;
	assign do_pop   = pop && avail;
	assign pop_data = slot_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/pcbp_front.sv @@
// ----------------------------------------------------------------------------
// pcbp_front
// Takes input words, writes the code table on load and looks up the code
// for encode and finish, handing left-aligned codes to the command queue.
// ----------------------------------------------------------------------------
module pcbp_front
	import pcbp_pkg::*;
#(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF,
	parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1),
	parameter int CMD_W        = MAX_CODE_LEN + LEN_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       action,
	input  logic [7:0]       symbol,
	input  logic [63:0]      code_word,
	input  logic [6:0]       code_length,
	output logic             push,
	output logic [CMD_W-1:0] push_data,
	input  logic             room
);

	localparam int CW     = MAX_CODE_LEN;
	localparam int ADDR_W = $clog2(NUM_SYMBOLS);
	localparam int ENT_W  = CW + LEN_W;
	localparam logic [LEN_W-1:0] CW_LEN = LEN_W'(MAX_CODE_LEN);
	localparam logic [ADDR_W-1:0] EOS_ADDR = ADDR_W'(NUM_SYMBOLS - 1);

	logic                   accept;
	logic                   in_range;
	logic                   is_load;
	logic                   is_lookup;
	logic                   is_finish;
	logic [ADDR_W-1:0]      sym_addr;
	logic [ADDR_W-1:0]      rd_addr;
	logic [LEN_W-1:0]       len_sat;
	logic [CW-1:0]          code_masked;
	logic                   we;
	logic [ENT_W-1:0]       rd_data;
	logic [NUM_SYMBOLS-1:0] len_vld_q;
	logic                   hit;
	logic                   valid_s1;
	logic                   fin_s1;
	logic                   hit_s1;
	logic [LEN_W-1:0]       len_eff;
	logic [CW-1:0]          code_left;

	always_comb begin
		is_load   = 1'b0;
		is_lookup = 1'b0;
		is_finish = 1'b0;
		unique case (action)
			ACT_LOAD:   is_load = 1'b1;
			ACT_ENCODE: is_lookup = 1'b1;
			ACT_FINISH: begin
				is_lookup = 1'b1;
				is_finish = 1'b1;
			end
			default: ;
		endcase
	end

	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && room;

	assign in_range = (int'(symbol) < NUM_SYMBOLS);
	assign sym_addr = ADDR_W'(symbol);
	assign rd_addr  = is_finish ? EOS_ADDR : sym_addr;
	assign we       = accept && is_load && in_range;

	// saturate the length and keep only its low code bits
	assign len_sat = (int'(code_length) > MAX_CODE_LEN) ? CW_LEN : LEN_W'(code_length);
	assign code_masked = code_word[CW-1:0] & ~({CW{1'b1}} << len_sat);

	// the length of a never-loaded entry reads as zero
	assign hit = is_finish ? len_vld_q[NUM_SYMBOLS-1] : (in_range && len_vld_q[sym_addr]);

	pcbp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(NUM_SYMBOLS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(sym_addr),
		.wdata({len_sat, code_masked}),
		.re   (accept && is_lookup),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_vld_q <= '0;
			valid_s1  <= 1'b0;
		end else begin
			if (we) begin
				len_vld_q[sym_addr] <= 1'b1;
			end
			if (accept) begin
				valid_s1 <= is_lookup;
			end else if (push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_lookup) begin
			fin_s1 <= is_finish;
			hit_s1 <= hit;
		end
	end

	// left-align the code; a zero length shifts everything out
	assign len_eff   = hit_s1 ? rd_data[ENT_W-1 -: LEN_W] : '0;
	assign code_left = rd_data[CW-1:0] << (CW_LEN - len_eff);
	assign push_data = {code_left, len_eff, fin_s1};

endmodule

@@ rtl/pcbp_back.sv @@
// ----------------------------------------------------------------------------
// pcbp_back
// Merges queued codes with pending bits, sends one byte per cycle while the
// output is not stalled, and pads and flags the last byte on finish.
// ----------------------------------------------------------------------------
module pcbp_back
	import pcbp_pkg::*;
#(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	parameter int LEN_W        = $clog2(MAX_CODE_LEN + 1),
	parameter int CMD_W        = MAX_CODE_LEN + LEN_W + 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             avail,
	input  logic [CMD_W-1:0] pop_data,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic             last
);

	localparam int CW    = MAX_CODE_LEN;
	localparam int WW    = CW + BYTE_W;
	localparam int CNT_W = $clog2(WW);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic              st_q;
	logic [WW-1:0]     work_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              fin_q;
	logic [PEND_W-1:0] pend_q;
	logic [PCNT_W-1:0] pcount_q;
	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic              last_q;

	logic [CW-1:0]     cmd_code;
	logic [LEN_W-1:0]  cmd_len;
	logic              cmd_fin;
	logic [WW-1:0]     merged;
	logic              slot_free;
	logic              emit_full;
	logic              emit_tail;
	logic              emit;

	assign cmd_code = pop_data[CMD_W-1 -: CW];
	assign cmd_len  = pop_data[LEN_W:1];
	assign cmd_fin  = pop_data[0];

	// pending bits are kept left-aligned, the new code follows them
	assign merged = {pend_q, {(CW + 1){1'b0}}} | ({cmd_code, {BYTE_W{1'b0}}} >> pcount_q);

	assign pop       = (st_q == ST_IDLE) && avail;
	assign slot_free = !out_valid_q || !out_stall;
	assign emit_full = (cnt_q >= CNT_W'(BYTE_W));
	assign emit_tail = fin_q && (cnt_q != '0) && !emit_full;
	assign emit      = (st_q == ST_RUN) && (emit_full || emit_tail) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			pend_q      <= '0;
			pcount_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (avail) begin
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (!emit_full && !emit_tail) begin
						// leftover bits wait for the next code
						pend_q   <= fin_q ? '0 : work_q[WW-1 -: PEND_W];
						pcount_q <= fin_q ? '0 : cnt_q[PCNT_W-1:0];
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			work_q <= merged;
			cnt_q  <= CNT_W'(pcount_q) + CNT_W'(cmd_len);
			fin_q  <= cmd_fin;
		end else if (emit) begin
			work_q <= work_q << BYTE_W;
			cnt_q  <= emit_full ? cnt_q - CNT_W'(BYTE_W) : '0;
		end
		if (emit) begin
			out_byte_q <= work_q[WW-1 -: BYTE_W];
			last_q     <= fin_q && (cnt_q <= CNT_W'(BYTE_W));
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

@@ rtl/prefix_code_bit_packer_top.sv @@
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_top
// Table-driven prefix-code encoder with an MSB-first byte packer.
// ----------------------------------------------------------------------------
// A load word writes one symbol's code and length into the code table. An
// encode or finish word reads the table (one RAM read, registered) and
// queues the left-aligned code; the front then takes a new word every cycle
// while the two-entry queue has room. The packing back takes a code from
// the queue, sends out its full bytes while the output is not stalled and
// then keeps the leftover bits, taking no new code until it is done.
// Finish appends the end-of-stream code, pads with zeros and marks the
// final byte with last; it sends no byte when nothing is pending and the
// end-of-stream code is empty. The table needs no clearing after reset:
// per-entry valid flags make unloaded symbols read as length zero.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer_top
	import pcbp_pkg::*;
#(
	parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
	parameter int NUM_SYMBOLS  = NUM_SYMBOLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  action,
	input  logic [7:0]  symbol,
	input  logic [63:0] code_word,
	input  logic [6:0]  code_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        last
);

	localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
	localparam int CMD_W = MAX_CODE_LEN + LEN_W + 1;

	logic             push;
	logic [CMD_W-1:0] push_data;
	logic             room;
	logic             pop;
	logic             avail;
	logic [CMD_W-1:0] pop_data;

	pcbp_front #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.NUM_SYMBOLS (NUM_SYMBOLS),
		.LEN_W       (LEN_W),
		.CMD_W       (CMD_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.symbol     (symbol),
		.code_word  (code_word),
		.code_length(code_length),
		.push       (push),
		.push_data  (push_data),
		.room       (room)
	);

	pcbp_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.room     (room),
		.pop      (pop),
		.avail    (avail),
		.pop_data (pop_data)
	);

	pcbp_back #(
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.LEN_W       (LEN_W),
		.CMD_W       (CMD_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.avail    (avail),
		.pop_data (pop_data),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.last     (last)
	);

endmodule

@@ rtl/pcbp_checker.sv @@
// ----------------------------------------------------------------------------
// pcbp_checker
// Port-level checks of the prefix code bit packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "prefix_code_bit_packer_top_assert.svh"

module pcbp_checker
	import pcbp_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  action,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_byte,
	input logic        last
);

	// a stalled output word holds
	`PCBP_AST_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(last))

	// input stall only follows a lookup word taken or an earlier stall
	`PCBP_AST_SAME(a_stall_origin, in_stall, $past(in_valid && !in_stall) || $past(in_stall))

	// a load or unused word leaves nothing in the lookup stage
	`PCBP_AST_NEXT(a_load_no_stall, in_valid && !in_stall && action != ACT_ENCODE && action != ACT_FINISH, !in_stall)

endmodule

bind prefix_code_bit_packer_top pcbp_checker u_pcbp_checker (.*);

@@ tb/prefix_code_bit_packer_top_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_top_tb
// Self-checking bench for the prefix code bit packer: table loads, symbol
// encodes and stream finishes go in, and every packed byte and its last flag
// is compared against an in-bench model of the code table and bit accumulator.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer_top_tb;
	import pcbp_pkg::*;

	localparam int NUM_SYMS = NUM_SYMBOLS_DEF;
	localparam int MAX_LEN = MAX_CODE_LEN_DEF;
	localparam int EOS_SYM = NUM_SYMS - 1;
	localparam logic [1:0] ACT_UNUSED = 2'd3;
	localparam int RANDOM_WORDS = 225;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [1:0]  act;
		logic [7:0]  sym;
		logic [63:0] code;
		logic [6:0]  len;
	} word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  action = ACT_LOAD;
	logic [7:0]  symbol = '0;
	logic [63:0] code_word = '0;
	logic [6:0]  code_length = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last;

	prefix_code_bit_packer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.symbol(symbol),
		.code_word(code_word),
		.code_length(code_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.last(last)
	);

	always #5 clk = ~clk;

	// stimulus side
	word_t pending_words[$];
	int    n_words = 1;
	int    words_sent = 0;
	int    useful_words = 0;
	bit    sym_loaded[0:NUM_SYMS-1];
	int    loaded_syms[$];
	bit    word_taken = 1'b0;
	word_t drive_word;

	// model of the packer
	logic [63:0] tbl_code[0:NUM_SYMS-1];
	int          tbl_len[0:NUM_SYMS-1];
	logic [7:0]  acc_bits = '0;
	int          acc_count = 0;
	logic [7:0]  expected_bytes[$];
	logic        expected_last[$];

	int fail_count = 0;
	int cycle_count = 0;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int rand_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(1, 12);
		if (r < 85) return $urandom_range(13, 32);
		if (r < 93) return $urandom_range(33, MAX_LEN);
		if (r < 97) return $urandom_range(MAX_LEN + 1, 127);
		return 0;
	endfunction

	task automatic add_word(input logic [1:0] act, input int sym, input logic [63:0] code,
		input int len);
		word_t w;
		w.act = act;
		w.sym = sym[7:0];
		w.code = code;
		w.len = len[6:0];
		pending_words.push_back(w);
		if (act == ACT_LOAD && sym < NUM_SYMS) begin
			if (!sym_loaded[sym]) begin
				sym_loaded[sym] = 1'b1;
				loaded_syms.push_back(sym);
			end
			useful_words++;
		end else if ((act == ACT_ENCODE && sym < NUM_SYMS) || act == ACT_FINISH) begin
			useful_words++;
		end
	endtask

	// msb-first shift into the accumulator, one byte out per eight bits
	task automatic shift_code(input logic [63:0] code, input int len);
		for (int i = len - 1; i >= 0; i--) begin
			acc_bits = {acc_bits[6:0], code[i]};
			acc_count++;
			if (acc_count == 8) begin
				expected_bytes.push_back(acc_bits);
				expected_last.push_back(1'b0);
				acc_bits = '0;
				acc_count = 0;
			end
		end
	endtask

	task automatic predict_bytes(input logic [1:0] act, input logic [7:0] sym,
		input logic [63:0] code, input logic [6:0] len);
		int         n_before;
		int         clamped;
		logic [7:0] padded;
		n_before = expected_bytes.size();
		case (act)
			ACT_LOAD: begin
				if (sym < NUM_SYMS) begin
					clamped = (len > MAX_LEN) ? MAX_LEN : int'(len);
					tbl_len[sym] = clamped;
					tbl_code[sym] = (clamped < 64) ? (code & ((64'd1 << clamped) - 64'd1)) : code;
				end
			end
			ACT_ENCODE: begin
				if (sym < NUM_SYMS)
					shift_code(tbl_code[sym], tbl_len[sym]);
			end
			ACT_FINISH: begin
				shift_code(tbl_code[EOS_SYM], tbl_len[EOS_SYM]);
				if (acc_count != 0) begin
					padded = acc_bits << (8 - acc_count);
					expected_bytes.push_back(padded);
					expected_last.push_back(1'b0);
				end
				if (expected_bytes.size() > n_before)
					expected_last[expected_last.size() - 1] = 1'b1;
				acc_bits = '0;
				acc_count = 0;
			end
			default: begin
			end
		endcase
	endtask

	// driver: new word only once the previous one is taken
	always @(negedge clk) begin
		int phase;
		int idle_pct;
		int stall_pct;
		phase = words_sent * 4 / (n_words + 1);
		case (phase)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 48;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 48;
			end
			default: begin
				idle_pct = 29;
				stall_pct = 29;
			end
		endcase
		if (arst_n) begin
			if (!in_valid || word_taken) begin
				if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
					drive_word = pending_words.pop_front();
					in_valid <= 1'b1;
					action <= drive_word.act;
					symbol <= drive_word.sym;
					code_word <= drive_word.code;
					code_length <= drive_word.len;
					words_sent++;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	// monitor: predict on accepted words, check accepted bytes
	always @(posedge clk) begin
		logic [7:0] exp_data;
		logic       exp_last;
		if (arst_n) begin
			word_taken = in_valid && !in_stall;
			if (word_taken)
				predict_bytes(action, symbol, code_word, code_length);
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected byte: out_byte=%02h last=%0b", out_byte, last);
					fail_count++;
				end else begin
					exp_data = expected_bytes.pop_front();
					exp_last = expected_last.pop_front();
					if (out_byte !== exp_data) begin
						$error("out_byte: expected %02h, got %02h", exp_data, out_byte);
						fail_count++;
					end
					if (last !== exp_last) begin
						$error("last: expected %0b, got %0b", exp_last, last);
						fail_count++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[prefix_code_bit_packer_top] ERROR");
			$finish;
		end
	end

	initial begin
		int r;
		int sym;
		for (int s = 0; s < NUM_SYMS; s++) begin
			tbl_code[s] = '0;
			tbl_len[s] = 0;
			sym_loaded[s] = 1'b0;
		end

		// directed: empty finish, extreme lengths, saturation, ignored words
		add_word(ACT_LOAD, EOS_SYM, rand64(), 0);
		add_word(ACT_FINISH, 0, rand64(), 0);
		add_word(ACT_LOAD, 0, '1, MAX_LEN);
		add_word(ACT_LOAD, 1, rand64(), 127);
		add_word(ACT_LOAD, 2, 64'd1, 1);
		add_word(ACT_LOAD, 3, '1, 0);
		add_word(ACT_LOAD, 4, rand64(), 7);
		add_word(ACT_LOAD, 255, rand64(), 5);
		add_word(ACT_UNUSED, $urandom_range(0, 255), rand64(), $urandom_range(0, 127));
		add_word(ACT_ENCODE, 0, rand64(), 127);
		add_word(ACT_ENCODE, 1, '0, 0);
		add_word(ACT_ENCODE, 2, rand64(), 0);
		add_word(ACT_ENCODE, 3, rand64(), 0);
		add_word(ACT_ENCODE, 200, rand64(), 0);
		// one bit pending, empty end-of-stream code: single padded last byte
		add_word(ACT_FINISH, 255, rand64(), 127);
		// seven pending bits plus a 64-bit end-of-stream code: longest flush
		add_word(ACT_ENCODE, 4, rand64(), 0);
		add_word(ACT_LOAD, EOS_SYM, rand64(), MAX_LEN);
		add_word(ACT_FINISH, 0, rand64(), 0);
		add_word(ACT_ENCODE, 2, rand64(), 0);
		add_word(ACT_LOAD, EOS_SYM, 64'd5, 3);
		add_word(ACT_FINISH, 0, rand64(), 0);
		add_word(ACT_ENCODE, EOS_SYM, rand64(), 0);
		add_word(ACT_FINISH, 0, rand64(), 0);

		// random: table updates, symbol runs, finish, with some noise
		useful_words = 0;
		while (useful_words < RANDOM_WORDS) begin
			repeat ($urandom_range(1, 6)) begin
				r = $urandom_range(0, 99);
				if (r < 80)
					sym = $urandom_range(0, 15);
				else if (r < 95)
					sym = $urandom_range(0, EOS_SYM);
				else
					sym = EOS_SYM;
				add_word(ACT_LOAD, sym, rand64(), rand_len());
			end
			repeat ($urandom_range(3, 20)) begin
				r = $urandom_range(0, 99);
				if (r < 2)
					add_word(ACT_UNUSED, $urandom_range(0, 255), rand64(), $urandom_range(0, 127));
				else if (r < 4)
					add_word(ACT_ENCODE, $urandom_range(NUM_SYMS, 255), rand64(), rand_len());
				else if (r < 6)
					add_word(ACT_LOAD, $urandom_range(NUM_SYMS, 255), rand64(), rand_len());
				else
					add_word(ACT_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
						rand64(), $urandom_range(0, 127));
			end
			if ($urandom_range(0, 9) != 0)
				add_word(ACT_FINISH, $urandom_range(0, 255), rand64(), $urandom_range(0, 127));
		end
		n_words = pending_words.size();

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_words.size() != 0 || in_valid || expected_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("[prefix_code_bit_packer_top] OK");
		else
			$display("[prefix_code_bit_packer_top] ERROR");
		$finish;
	end

endmodule
